>>> rtl/dsc_pkg.sv
package dsc_pkg;

  // Frame layout constants.
  localparam int          COUNT_W       = 7;
  localparam logic [6:0]  COUNT_MAX     = 7'd127;
  localparam logic [7:0]  SEQ_TAG       = 8'h30;
  localparam logic [7:0]  INT_TAG       = 8'h02;
  localparam logic [7:0]  MIN_SIG_BYTES = 8'd8;
  localparam logic [7:0]  MAX_SIG_BYTES = 8'd72;
  localparam logic [7:0]  SCHNORR_BYTES = 8'd64;

  // Queue between the byte parser and the status stage.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SCHNORR_ENABLED  = 2'd0,
    CFG_ECDSA_ONLY       = 2'd1,
    CFG_DER_CHECK_ENABLE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_SCHNORR = 2'd1,
    STATUS_BAD_DER     = 2'd2
  } status_t;

  typedef struct packed {
    logic schnorr_enabled;
    logic ecdsa_only;
    logic der_check_enable;
  } cfg_t;

  // Everything the status stage needs about one finished signature.
  typedef struct packed {
    logic       size_known;
    logic [7:0] size;
    logic       der_error;
    logic [7:0] total_length;
    logic [7:0] r_length;
    logic [7:0] s_length;
  } frame_sum_t;

endpackage

>>> rtl/dsc_front.sv
module dsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          sig_byte,
  input  logic                is_last,
  input  logic                push,
  input  logic                q_full,
  output logic                full,
  output logic                sum_valid,
  output dsc_pkg::frame_sum_t sum
);
  import dsc_pkg::*;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]         total_length, total_length_next;
  logic [7:0]         r_length, r_length_next;
  logic [7:0]         s_length, s_length_next;
  logic [7:0]         r_first, r_first_next;
  logic [7:0]         s_first, s_first_next;
  logic               der_error, der_error_next;

  logic       accept;
  logic       saturated;
  logic [8:0] pos;
  logic [8:0] s_tag;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign saturated = (byte_count == COUNT_MAX);
  assign pos       = {2'b00, byte_count};
  assign s_tag     = {1'b0, r_length} + 9'd4;

  always_comb begin
    byte_count_next   = byte_count;
    total_length_next = total_length;
    r_length_next     = r_length;
    s_length_next     = s_length;
    r_first_next      = r_first;
    s_first_next      = s_first;
    der_error_next    = der_error;
    if (!saturated) begin
      if (pos == 9'd0 && sig_byte != SEQ_TAG) der_error_next = 1'b1;
      if (pos == 9'd1) total_length_next = sig_byte;
      if (pos == 9'd2 && sig_byte != INT_TAG) der_error_next = 1'b1;
      if (pos == 9'd3) begin
        r_length_next = sig_byte;
        if (sig_byte == 8'd0) der_error_next = 1'b1;
      end
      if (pos == 9'd4) begin
        r_first_next = sig_byte;
        if (sig_byte[7]) der_error_next = 1'b1;
      end
      if (pos == 9'd5 && r_length > 8'd1 && r_first == 8'd0 && !sig_byte[7]) begin
        der_error_next = 1'b1;
      end
      if (pos == s_tag && sig_byte != INT_TAG) der_error_next = 1'b1;
      if (pos == s_tag + 9'd1) begin
        s_length_next = sig_byte;
        if (sig_byte == 8'd0) der_error_next = 1'b1;
      end
      if (pos == s_tag + 9'd2) begin
        s_first_next = sig_byte;
        if (sig_byte[7]) der_error_next = 1'b1;
      end
      if (pos == s_tag + 9'd3 && s_length > 8'd1 && s_first == 8'd0 && !sig_byte[7]) begin
        der_error_next = 1'b1;
      end
      byte_count_next = byte_count + 1'b1;
    end
  end

  // The summary carries the state as it stands after the last byte.
  assign sum_valid        = accept && is_last;
  assign sum.size_known   = !saturated;
  assign sum.size         = {1'b0, byte_count} + 8'd1;
  assign sum.der_error    = der_error_next;
  assign sum.total_length = total_length_next;
  assign sum.r_length     = r_length_next;
  assign sum.s_length     = s_length_next;

  always_ff @(posedge clk) begin
    if (rst || (accept && is_last)) begin
      byte_count   <= '0;
      total_length <= '0;
      r_length     <= '0;
      s_length     <= '0;
      r_first      <= '0;
      s_first      <= '0;
      der_error    <= 1'b0;
    end else if (accept) begin
      byte_count   <= byte_count_next;
      total_length <= total_length_next;
      r_length     <= r_length_next;
      s_length     <= s_length_next;
      r_first      <= r_first_next;
      s_first      <= s_first_next;
      der_error    <= der_error_next;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last) |=> (byte_count == '0 && !der_error))
    else $error("frame state not cleared after the last byte");

endmodule

>>> rtl/dsc_queue.sv
module dsc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dsc_pkg::frame_sum_t wr_data,
  input  logic                pop,
  output dsc_pkg::frame_sum_t rd_data,
  output logic                full,
  output logic                empty
);
  import dsc_pkg::*;

  frame_sum_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("summary pushed into a full queue");

endmodule

>>> rtl/dsc_back.sv
module dsc_back (
  input  logic                clk,
  input  logic                rst,
  input  dsc_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  dsc_pkg::frame_sum_t sum,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_pop,
  output dsc_pkg::status_t    status
);
  import dsc_pkg::*;

  status_t    status_next;
  logic       take;
  logic       der_ok;
  logic [9:0] len_sum;

  assign take    = !q_empty && (!out_valid || out_pop);
  assign q_pop   = take;
  assign len_sum = {2'b00, sum.r_length} + {2'b00, sum.s_length} + 10'd6;

  // Size bounds guard the subtractions, so wrap below 8 never matters.
  assign der_ok = sum.size_known && !sum.der_error &&
                  sum.size >= MIN_SIG_BYTES && sum.size <= MAX_SIG_BYTES &&
                  sum.total_length == sum.size - 8'd2 &&
                  sum.r_length <= sum.size - 8'd7 &&
                  len_sum == {2'b00, sum.size};

  always_comb begin
    if (cfg.schnorr_enabled && sum.size_known && sum.size == SCHNORR_BYTES) begin
      status_next = cfg.ecdsa_only ? STATUS_BAD_SCHNORR : STATUS_OK;
    end else if (cfg.der_check_enable) begin
      status_next = der_ok ? STATUS_OK : STATUS_BAD_DER;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status <= status_next;
    end
  end

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> out_valid)
    else $error("status stage took a summary but shows no result");

endmodule

>>> rtl/der_signature_encoding_check_unit.sv
// Strict DER signature encoding check.
// Input channel: one signature byte per beat on sig_byte, with is_last high
// on the final byte (sighash byte already removed). A beat is taken when
// push is high and full is low; a new byte can be taken every cycle while full stays low.
// Result channel: one status_code per signature (0 ok, 1 bad Schnorr length,
// 2 bad DER form). The result is valid while empty is low and is taken by
// pop. The status of a signature passes first through the summary queue,
// written by the edge that takes its last byte, and then the output register,
// which is loaded from the queue once it is free.
// Throughput is one byte per cycle while full is low, set by the byte parser,
// which looks at each byte once as it arrives.
// Configuration: cfg_valid/cfg_ready (always ready) write cfg_data to the
// register selected by cfg_index: 0 Schnorr enable, 1 ECDSA-only context,
// 2 DER check enable. Write only while no signature is in flight.
// Reset (rst, synchronous) clears the frame state, empties the queue and the
// output register, and sets the registers to 0, 0 and 1.
// When the receiver stalls, finished summaries collect in a four-entry queue;
// full rises only when that queue and the output register are all occupied.
module der_signature_encoding_check_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [7:0]                          sig_byte,
  input  logic                                is_last,
  output logic                                empty,
  input  logic                                pop,
  output dsc_pkg::status_t                    status_code,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic                                cfg_data
);
  import dsc_pkg::*;

  cfg_t       cfg;
  logic       sum_valid;
  frame_sum_t sum_in;
  frame_sum_t sum_out;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       out_valid;

  // Register writes are accepted in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.schnorr_enabled  <= 1'b0;
      cfg.ecdsa_only       <= 1'b0;
      cfg.der_check_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SCHNORR_ENABLED:  cfg.schnorr_enabled  <= cfg_data;
        CFG_ECDSA_ONLY:       cfg.ecdsa_only       <= cfg_data;
        CFG_DER_CHECK_ENABLE: cfg.der_check_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: parses bytes and hands a summary over at the last byte.
  dsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .sig_byte  (sig_byte),
    .is_last   (is_last),
    .push      (push),
    .q_full    (q_full),
    .full      (full),
    .sum_valid (sum_valid),
    .sum       (sum_in)
  );

  // Short queue that lets the parser run while results wait.
  dsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (sum_valid),
    .wr_data (sum_in),
    .pop     (q_pop),
    .rd_data (sum_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back: length checks and the status register on the result side.
  dsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .sum       (sum_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_pop   (pop),
    .status    (status_code)
  );

  assign empty = !out_valid;

endmodule
